FILE: rtl/core/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
// No dependencies.
package bfa_pkg;

   localparam int MAX_FRAMES   = 4096;
   localparam int WORD_BITS    = 32;
   localparam int MAP_WORDS    = MAX_FRAMES / WORD_BITS;
   localparam int WORD_IDX_W   = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W    = $clog2(WORD_BITS);
   localparam int FRAME_W      = 13;
   localparam int FRAME_SHIFT  = 12;
   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_RESERVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_OOM     = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_WALK,
      B_DONE
   } back_state_type;

   // Work item handed from front to back: frame range [lo, hi) and a
   // flag for items that need no map access.
   typedef struct packed {
      cmd_type              cmd;
      logic [FRAME_W-1:0]   lo;
      logic [FRAME_W-1:0]   hi;
      logic                 skip;
   } work_type;

endpackage

FILE: rtl/core/bfa_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/bfa_front.sv
// Front end: frame count register, input acceptance and command decode.
// Depends on bfa_pkg.
module bfa_front import bfa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_command,
   input  logic [31:0]          req_address,
   input  logic [32:0]          req_end_address,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [FRAME_W-1:0]   csr_wdata,
   output logic [FRAME_W-1:0]   frame_count,
   input  logic                 queue_full,
   output logic                 push,
   output work_type             work
);

   logic [FRAME_W-1:0] frame_count_ff, frame_count_in;
   logic [FRAME_W-1:0] cnt;
   logic [19:0]        free_f;
   logic [32:0]        rel_sum;
   logic [20:0]        start_f, end_f;
   logic [FRAME_W-1:0] end_c;
   cmd_type            cmd;

   always_comb begin
      frame_count_in = frame_count_ff;
      if (csr_write && csr_index == 1'b0) begin
         frame_count_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_W'(MAX_FRAMES);
      end else begin
         frame_count_ff <= frame_count_in;
      end
   end

   assign frame_count = frame_count_ff;
   assign req_tready  = !queue_full;
   assign push        = req_tvalid && !queue_full;

   always_comb begin
      cmd     = cmd_type'(req_command);
      cnt     = (frame_count_ff > FRAME_W'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES)
                                                         : frame_count_ff;
      free_f  = req_address[31:FRAME_SHIFT];
      rel_sum = {1'b0, req_address} + 33'h0_0000_0FFF;
      start_f = (cmd == CMD_RELEASE) ? rel_sum[32:FRAME_SHIFT]
                                     : {1'b0, req_address[31:FRAME_SHIFT]};
      end_f   = req_end_address[32:FRAME_SHIFT];
      end_c   = (end_f > {8'd0, cnt}) ? cnt : end_f[FRAME_W-1:0];

      work.cmd = cmd;
      unique case (cmd)
         CMD_ALLOC: begin
            work.lo   = '0;
            work.hi   = cnt;
            work.skip = (cnt == '0);
         end
         CMD_FREE: begin
            work.lo   = free_f[FRAME_W-1:0];
            work.hi   = free_f[FRAME_W-1:0] + FRAME_W'(1);
            work.skip = (free_f >= {7'd0, cnt});
         end
         default: begin
            work.lo   = start_f[FRAME_W-1:0];
            work.hi   = end_c;
            work.skip = (start_f >= {8'd0, end_c});
         end
      endcase
   end

endmodule

FILE: rtl/core/bfa_queue.sv
// Short FIFO of decoded work items between front and back.
// Depends on bfa_pkg.
module bfa_queue import bfa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  work_type  push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output work_type  head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   work_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [PTR_W:0]       level_ff, level_in;

   assign full      = (level_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (level_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         level_in = level_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/bfa_back.sv
// Back end: walks the used map one word per cycle, keeps the used counter
// and holds the result register. Depends on bfa_pkg and bfa_ram.
module bfa_back import bfa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                work_valid,
   input  work_type            work,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [1:0]          rsp_status,
   output logic [31:0]         rsp_frame_address,
   output logic [FRAME_W-1:0]  rsp_used_count
);

   localparam logic [WORD_BITS-1:0] ONES = '1;

   back_state_type state_ff, state_in;

   cmd_type                cmd_ff, cmd_in;
   logic [FRAME_W-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [WORD_IDX_W-1:0]  cur_w_ff, cur_w_in, last_w_ff, last_w_in;
   logic [FRAME_W-1:0]     counter_ff, counter_in;
   status_type             res_status_ff, res_status_in;
   logic [31:0]            res_addr_ff, res_addr_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_addr_ff, rsp_addr_in;
   logic [FRAME_W-1:0]     rsp_count_ff, rsp_count_in;

   // valid bit per map word: an unwritten word reads as all used
   logic [MAP_WORDS-1:0]   valid_ff;
   logic                   rd_valid_ff;

   logic                   we;
   logic [WORD_BITS-1:0]   wdata, rdata, word;
   logic [WORD_IDX_W-1:0]  raddr;

   logic [FRAME_W-1:0]     hm1, work_hm1;
   logic [BIT_IDX_W-1:0]   lo_bit;
   logic [BIT_IDX_W:0]     hi_bit;
   logic [WORD_BITS-1:0]   mask, free_bits, first_free;
   logic [BIT_IDX_W-1:0]   first_idx;
   logic                   is_last;
   logic [FRAME_W:0]       sum;

   bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
      .clock (clock),
      .we    (we),
      .waddr (cur_w_ff),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[cur_w_ff] <= 1'b1;
      end
      rd_valid_ff <= valid_ff[raddr];
   end

   always_comb begin
      word      = rd_valid_ff ? rdata : ONES;
      hm1       = hi_ff - FRAME_W'(1);
      work_hm1  = work.hi - FRAME_W'(1);
      is_last   = (cur_w_ff == last_w_ff);
      lo_bit    = (cur_w_ff == lo_ff[FRAME_W-2:BIT_IDX_W]) ? lo_ff[BIT_IDX_W-1:0] : '0;
      hi_bit    = is_last ? ({1'b0, hm1[BIT_IDX_W-1:0]} + (BIT_IDX_W+1)'(1))
                          : (BIT_IDX_W+1)'(WORD_BITS);
      mask      = (ONES << lo_bit) & ~(ONES << hi_bit);
      free_bits = ~word & mask;
      first_free = free_bits & (~free_bits + WORD_BITS'(1));
      first_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (first_free[i]) begin
            first_idx = BIT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cur_w_in      = cur_w_ff;
      last_w_in     = last_w_ff;
      counter_in    = counter_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_count_in  = rsp_count_ff;
      pop           = 1'b0;
      we            = 1'b0;
      wdata         = word;
      raddr         = cur_w_ff;
      sum           = '0;

      unique case (state_ff)
         B_IDLE: begin
            if (work_valid) begin
               pop         = 1'b1;
               cmd_in      = work.cmd;
               lo_in       = work.lo;
               hi_in       = work.hi;
               res_addr_in = '0;
               if (work.skip) begin
                  unique case (work.cmd)
                     CMD_ALLOC: res_status_in = ST_OOM;
                     CMD_FREE:  res_status_in = ST_INVALID;
                     default:   res_status_in = ST_OK;
                  endcase
                  state_in = B_DONE;
               end else begin
                  res_status_in = ST_OK;
                  raddr         = work.lo[FRAME_W-2:BIT_IDX_W];
                  cur_w_in      = work.lo[FRAME_W-2:BIT_IDX_W];
                  last_w_in     = work_hm1[FRAME_W-2:BIT_IDX_W];
                  state_in      = B_WALK;
               end
            end
         end
         B_WALK: begin
            raddr = cur_w_ff + WORD_IDX_W'(1);
            unique case (cmd_ff)
               CMD_ALLOC: begin
                  if (free_bits != '0) begin
                     we          = 1'b1;
                     wdata       = word | first_free;
                     sum         = {1'b0, counter_ff} + (FRAME_W+1)'(1);
                     counter_in  = (sum > (FRAME_W+1)'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES)
                                                                     : sum[FRAME_W-1:0];
                     res_addr_in = 32'({cur_w_ff, first_idx}) << FRAME_SHIFT;
                     state_in    = B_DONE;
                  end else if (is_last) begin
                     res_status_in = ST_OOM;
                     state_in      = B_DONE;
                  end else begin
                     cur_w_in = cur_w_ff + WORD_IDX_W'(1);
                  end
               end
               CMD_FREE: begin
                  we         = 1'b1;
                  wdata      = word & ~mask;
                  counter_in = (counter_ff != '0) ? counter_ff - FRAME_W'(1) : '0;
                  state_in   = B_DONE;
               end
               CMD_RELEASE: begin
                  we    = 1'b1;
                  wdata = word & ~mask;
                  if (is_last) begin
                     state_in = B_DONE;
                  end else begin
                     cur_w_in = cur_w_ff + WORD_IDX_W'(1);
                  end
               end
               default: begin
                  we    = 1'b1;
                  wdata = word | mask;
                  if (is_last) begin
                     sum        = {1'b0, counter_ff} + {1'b0, hi_ff - lo_ff};
                     counter_in = (sum > (FRAME_W+1)'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES)
                                                                    : sum[FRAME_W-1:0];
                     state_in   = B_DONE;
                  end else begin
                     cur_w_in = cur_w_ff + WORD_IDX_W'(1);
                  end
               end
            endcase
         end
         default: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_count_in  = counter_ff;
               state_in      = B_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cur_w_ff      <= cur_w_in;
      last_w_ff     <= last_w_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame_address = rsp_addr_ff;
   assign rsp_used_count    = rsp_count_ff;

endmodule

FILE: rtl/core/bitmap_frame_allocator_unit.sv
// Top level of the bitmap frame allocator: front, work queue and back.
// Depends on bfa_pkg, bfa_front, bfa_queue, bfa_back (and bfa_ram).
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   req_     | in        | tuser: command; tdata: address, end_address
//   rsp_     | out       | tuser: status; tdata: frame_address, used_count
//   csr_     | in/out    | frame_count at byte address 0
//
// Walk: an item that touches no map word skips the walk; else the back walks
//   the words of its range, up to 128 for a full allocate search or range;
//   the map RAM reads one 32-bit word per cycle.
// Reset: synchronous; the map reads as all used through per-word valid bits,
//   the used counter is zero and frame_count is 4096. No clearing pass.
// Stalls: a two-item queue lets the front take items while the back walks;
//   the result register frees the back from a stalled rsp_ side for one item.
module bitmap_frame_allocator_unit import bfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,  // [31:0] address, [64:32] end_address, zero above
   input  logic [1:0]   req_tuser,  // [1:0] command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // [31:0] frame_address, [44:32] used_count, zero above
   output logic [1:0]   rsp_tuser,  // [1:0] status
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic               csr_write;
   logic [FRAME_W-1:0] frame_count;
   logic               push, queue_full, work_valid, pop;
   work_type           push_work, head_work;
   logic [31:0]        frame_address;
   logic [FRAME_W-1:0] used_count;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   // only register 0 exists; addresses with bit 2 set read zero
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {19'd0, frame_count} : 32'd0;

   bfa_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_command     (req_tuser),
      .req_address     (req_tdata[31:0]),
      .req_end_address (req_tdata[64:32]),
      .csr_write       (csr_write),
      .csr_index       (csr_paddr[2]),
      .csr_wdata       (csr_pwdata[FRAME_W-1:0]),
      .frame_count     (frame_count),
      .queue_full      (queue_full),
      .push            (push),
      .work            (push_work)
   );

   bfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_work),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (work_valid),
      .head      (head_work)
   );

   bfa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .work_valid        (work_valid),
      .work              (head_work),
      .pop               (pop),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_status        (rsp_tuser),
      .rsp_frame_address (frame_address),
      .rsp_used_count    (used_count)
   );

   assign rsp_tdata = {3'd0, used_count, frame_address};

endmodule

FILE: rtl/core/bfa_checker.sv
// Port-level checks for the bitmap frame allocator, bound to the top level.
// Depends on bfa_pkg and bitmap_frame_allocator_unit.
module bfa_port_checks import bfa_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [47:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[44:32] <= 13'(MAX_FRAMES))
      else $error("used count beyond maximum");

   a_addr_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:0] == 12'd0 && rsp_tdata[47:45] == 3'd0)
      else $error("frame address not frame aligned");

   a_addr_ok_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31:0] != 32'd0 |-> rsp_tuser == ST_OK)
      else $error("frame address on failed item");

endmodule

bind bitmap_frame_allocator_unit bfa_port_checks u_bfa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: dv/bfa_checker.sv
`timescale 1ns / 100ps
// Checker for the bitmap frame allocator: watches req_, rsp_ and csr_ traffic,
// keeps its own copy of the used map, counter and frame_count. Depends on bfa_pkg.
module bfa_checker import bfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [71:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [47:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending
);

   localparam logic [2:0] ADDR_FRAME_COUNT = 3'd0;

   typedef struct {
      status_type  status;
      logic [31:0] faddr;
      logic [12:0] used;
   } alloc_result_type;

   bit               frame_busy [MAX_FRAMES];
   int unsigned      busy_total;
   logic [12:0]      frame_limit;
   alloc_result_type expected_q[$];

   function automatic int unsigned active_frames();
      return (frame_limit > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit);
   endfunction

   function automatic void bump_used(longint unsigned n);
      longint unsigned v;
      v = busy_total + n;
      busy_total = (v > MAX_FRAMES) ? MAX_FRAMES : int'(v);
   endfunction

   // Range commands: [lo, hi) with hi clamped to the active frame count
   function automatic void mark_range(longint unsigned lo, longint unsigned hi, bit busy);
      longint unsigned lim;
      lim = active_frames();
      if (hi > lim) hi = lim;
      if (lo >= hi) return;
      for (longint unsigned f = lo; f < hi; f++) frame_busy[f] = busy;
      if (busy) bump_used(hi - lo);
   endfunction

   function automatic alloc_result_type run_command(cmd_type c, logic [31:0] a,
                                                    logic [32:0] e);
      alloc_result_type r;
      int unsigned      cnt;
      int               hit;
      longint unsigned  f;
      cnt = active_frames();
      r.status = ST_OK;
      r.faddr = '0;
      hit = -1;
      case (c)
         CMD_ALLOC: begin
            for (int i = 0; i < cnt; i++)
               if (!frame_busy[i]) begin
                  hit = i;
                  break;
               end
            if (hit < 0) r.status = ST_OOM;
            else begin
               frame_busy[hit] = 1'b1;
               bump_used(1);
               r.faddr = 32'(hit) << FRAME_SHIFT;
            end
         end
         CMD_FREE: begin
            f = a >> FRAME_SHIFT;
            if (f >= cnt) r.status = ST_INVALID;
            else begin
               frame_busy[f] = 1'b0;
               if (busy_total > 0) busy_total--;
            end
         end
         CMD_RELEASE: mark_range((longint'(a) + 'hFFF) >> FRAME_SHIFT,
                                 longint'(e) >> FRAME_SHIFT, 1'b0);
         default:     mark_range(longint'(a) >> FRAME_SHIFT,
                                 longint'(e) >> FRAME_SHIFT, 1'b1);
      endcase
      r.used = 13'(busy_total);
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type exp_r;
      if (reset) begin
         foreach (frame_busy[i]) frame_busy[i] = 1'b1;
         busy_total = 0;
         frame_limit = 13'd4096;
         expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == ADDR_FRAME_COUNT)
            frame_limit = csr_pwdata[12:0];
         if (req_tvalid && req_tready)
            expected_q.push_back(run_command(cmd_type'(req_tuser), req_tdata[31:0],
                                             req_tdata[64:32]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected rsp item: status %0d addr %h used %0d",
                      rsp_tuser, rsp_tdata[31:0], rsp_tdata[44:32]);
               fail_count++;
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_tuser !== exp_r.status) begin
                  $error("status: expected %0d, actual %0d", exp_r.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[31:0] !== exp_r.faddr) begin
                  $error("frame_address: expected %h, actual %h",
                         exp_r.faddr, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[44:32] !== exp_r.used) begin
                  $error("used_count: expected %0d, actual %0d",
                         exp_r.used, rsp_tdata[44:32]);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

FILE: dv/tb_bitmap_frame_allocator_unit.sv
`timescale 1ns / 100ps
// Testbench top for bitmap_frame_allocator_unit: clock, reset, stimulus and verdict.
// Depends on bfa_pkg, the RTL and bfa_checker.
module tb_bitmap_frame_allocator_unit;
   import bfa_pkg::*;

   localparam int         IDLE_LIMIT       = 4000;  // cycles with no item moving
   localparam int         HOLD_CYCLES      = 500;   // long rsp_ back-pressure stretch
   localparam int         DRAIN_CYCLES     = 140;   // about one full map walk
   localparam int         ITEMS_PER_PHASE  = 93;
   localparam logic [2:0] ADDR_FRAME_COUNT = 3'd0;
   localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;  // register index 1, not present

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;   // [31:0] address, [64:32] end_address
   logic [1:0]   req_tuser = '0;   // [1:0] command
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;        // [31:0] frame_address, [44:32] used_count
   logic [1:0]   rsp_tuser;        // [1:0] status
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int fail_count;
   int pending;
   int items_sent = 0;
   int csr_writes = 0;
   int idle_cycles = 0;
   int cur_frames = 4096;  // active frame count as programmed
   bit no_gaps = 1'b0;     // both sides run back to back
   bit hold_rsp = 1'b0;    // request for a long receiver hold-off

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bitmap_frame_allocator_unit dut (.*);

   bfa_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .pending
   );

   // Watchdog: a hung block shows up as a long run of cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("bitmap_frame_allocator_unit: mismatch");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Receiver: random stall per item, plus one long hold-off on request
   initial begin
      int n;
      @(negedge clock iff !reset);
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 17);
         if (hold_rsp) begin
            n = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // Sender: one item, after a random gap; valid stays high when no gap
   task automatic send_item(cmd_type c, logic [31:0] a, logic [32:0] e);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= c;
      req_tdata  <= {7'd0, e, a};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
      items_sent++;
   endtask

   // Registers change only with the block drained
   task automatic write_csr(logic [2:0] addr, logic [31:0] value);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_writes++;
      if (addr == ADDR_FRAME_COUNT)
         cur_frames = (value[12:0] > MAX_FRAMES) ? MAX_FRAMES : int'(value[12:0]);
   endtask

   // Addresses mostly land near the managed frames, a few are fully random
   function automatic logic [31:0] pick_addr(int top_frame);
      logic [31:0] low;
      if ($urandom_range(0, 9) == 0) return $urandom;
      low = $urandom_range(0, 1) ? 32'($urandom_range(0, 4095)) : 32'd0;
      return (32'($urandom_range(0, top_frame)) << FRAME_SHIFT) | low;
   endfunction

   task automatic send_random();
      int          r;
      int          span;
      cmd_type     c;
      logic [31:0] a;
      logic [32:0] e;
      r = $urandom_range(0, 99);
      c = (r < 40) ? CMD_ALLOC : (r < 65) ? CMD_FREE : (r < 80) ? CMD_RELEASE : CMD_RESERVE;
      a = pick_addr(cur_frames + 1);
      if ($urandom_range(0, 9) == 0)
         e = {1'($urandom), 32'($urandom)};
      else begin
         span = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cur_frames + 2)
                                            : $urandom_range(0, 8);
         e = ((33'(a) >> FRAME_SHIFT) + 33'(span)) << FRAME_SHIFT;
         if ($urandom_range(0, 1)) e[11:0] = 12'($urandom);
      end
      send_item(c, a, e);
   endtask

   initial begin
      int settings[7] = '{37, 200, 8191, 1, 64, 4095, 4096};
      int timeout;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: everything starts used with the counter at zero
      send_item(CMD_ALLOC,   32'h0,         33'h0);          // out of memory
      send_item(CMD_FREE,    32'h0,         33'h0);          // counter stays at zero
      send_item(CMD_FREE,    32'hFFFF_F000, 33'h0);          // beyond the count
      send_item(CMD_RELEASE, 32'h1,         33'h1_FFFF_FFFF); // start rounds up
      send_item(CMD_ALLOC,   32'h0,         33'h0);
      send_item(CMD_RESERVE, 32'h0,         33'h3FFF);
      send_item(CMD_FREE,    32'h5000,      33'h0);          // already free
      send_item(CMD_RELEASE, 32'h5000,      33'h5000);       // empty range
      send_item(CMD_RESERVE, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF); // start past the count
      send_item(CMD_RESERVE, 32'h00FF_E000, 33'h1_0000_0000); // end clamped
      send_item(CMD_RELEASE, 32'h0,         33'h1000_0000);
      send_item(CMD_ALLOC,   32'h0,         33'h0);
      send_item(CMD_ALLOC,   32'h0,         33'h0);
      send_item(CMD_FREE,    32'h2FFF,      33'h0);
      send_item(CMD_RESERVE, 32'h0,         33'h1_FFFF_FFFF); // counter saturates
      send_item(CMD_ALLOC,   32'h0,         33'h0);          // map full
      send_item(CMD_FREE,    32'h00FF_F000, 33'h0);          // last frame
      send_item(CMD_ALLOC,   32'h0,         33'h0);
      write_csr(ADDR_FRAME_COUNT, 32'd0);                    // nothing managed
      send_item(CMD_ALLOC,   32'h0,         33'h0);
      send_item(CMD_FREE,    32'h0,         33'h0);
      send_item(CMD_RELEASE, 32'h0,         33'h1_FFFF_FFFF);
      write_csr(ADDR_UNMAPPED, 32'd5);                       // ignored
      send_item(CMD_ALLOC,   32'h0,         33'h0);

      // Random phases, one frame count each
      foreach (settings[p]) begin
         write_csr(ADDR_FRAME_COUNT, settings[p]);
         no_gaps  = (p == 2);
         hold_rsp = (p == 1);  // sender keeps offering while rsp_ is held
         repeat (ITEMS_PER_PHASE) send_random();
      end
      req_tvalid <= 1'b0;

      timeout = 0;
      while (pending != 0 && timeout < 20 * IDLE_LIMIT) begin
         @(negedge clock);
         timeout++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d items over %0d register writes, frame counts 0 to 8191,",
               items_sent, csr_writes);
      $display("with random gaps, back-to-back runs and one long rsp_ hold-off.");
      if (fail_count == 0 && pending == 0)
         $display("bitmap_frame_allocator_unit: match");
      else
         $display("bitmap_frame_allocator_unit: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/bfa_front.sv
rtl/core/bfa_queue.sv
rtl/core/bfa_back.sv
rtl/core/bitmap_frame_allocator_unit.sv
rtl/core/bfa_checker.sv
dv/bfa_checker.sv
dv/tb_bitmap_frame_allocator_unit.sv
